// ----- hdl/linear_probe_hash_map_macros.svh -----
// ----------------------------------------------------------------------------
// linear_probe_hash_map_macros.svh
// Assertion macros shared by the hash map checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LPHM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define LPHM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/lphm_pkg.sv -----
// ----------------------------------------------------------------------------
// lphm_pkg
// Beat types, status codes, hash constants and state encodings for the
// linear probing hash map.
// ----------------------------------------------------------------------------
package lphm_pkg;

  // Request beat
  typedef struct packed {
    logic        func;
    logic [63:0] key;
    logic [63:0] value;
  } in_t;

  // Response beat
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] result_value;
  } out_t;

  // Operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // Status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_DUP       = 3'd3;
  localparam logic [2:0] STAT_RESERVED  = 3'd4;

  // Slot codes
  localparam logic [63:0] KEY_EMPTY = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] KEY_TOMB  = 64'hffff_ffff_ffff_fffe;

  // Mix constants; the initial hash word is seed ^ (8 * multiplier)
  localparam logic [63:0] MIX_MUL   = 64'hc6a4_a793_5bd1_e995;
  localparam int unsigned MIX_SHIFT = 47;
  localparam logic [63:0] MIX_SEED  = 64'h8445_d61a_4e77_4912;
  localparam logic [63:0] MIX_H0    = MIX_SEED ^ {MIX_MUL[60:0], 3'b000};

  // Hash unit states
  typedef enum logic [1:0] {
    MIX_IDLE,
    MIX_RUN,
    MIX_MOD
  } mix_state_t;

  // Main controller states
  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    HASH,
    PROBE,
    FINISH
  } ctrl_state_t;

endpackage

// ----- hdl/linear_probe_hash_map.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open addressing map from 64-bit keys to 64-bit values, linear probing.
// ----------------------------------------------------------------------------
// A request beat (req) carries func (0 lookup, 1 insert), key and value; each
// request yields one response beat (rsp) with status and result_value.
// Keys all-ones and all-ones minus one are reserved and answered at once.
// One request is worked at a time. The home slot comes from the shared
// 32x32 multiplier (four 64-bit products in turn), plus a reduction modulo
// the table size when TABLE_ENTRIES is not a power of two. The probe then
// reads one slot a cycle from the key/value memories, and an insert writes
// its slot in the last probe cycle.
// After reset the key memory is swept to empty, one slot a cycle, with
// req_ready low. The response sits in an output register; req_ready returns
// while it waits, and a second result waits in the controller until
// rsp_ready takes the first.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  lphm_pkg::in_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output lphm_pkg::out_t  rsp
);

  localparam int unsigned    IDX_W    = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

  lphm_pkg::ctrl_state_t state, state_next;

  // Request held during the probe
  logic             func_r;
  logic [63:0]      key_r;
  logic [63:0]      val_r;

  // Probe bookkeeping
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] issue_pos;
  logic [IDX_W-1:0] chk_pos;
  logic             chk_vld;
  logic [IDX_W-1:0] nchk;
  logic             have_free;
  logic [IDX_W-1:0] free_pos;
  logic [2:0]       status_r;
  logic [63:0]      rv_r;

  // Hash unit and memory hookup
  logic             mix_start;
  logic             mix_done;
  logic [IDX_W-1:0] home;
  logic [63:0]      rd_key;
  logic [63:0]      rd_val;
  logic             key_we;
  logic             val_we;
  logic [IDX_W-1:0] waddr;
  logic [63:0]      wr_key;

  // Probe decode
  logic             req_rsvd;
  logic             hit;
  logic             slot_empty;
  logic             slot_free;
  logic             free_any;
  logic [IDX_W-1:0] free_sel;
  logic             probe_end;
  logic             ins_write;
  logic [2:0]       probe_status;
  logic [63:0]      probe_rv;
  logic             rsp_load;

  lphm_mix #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .key   (req.key),
    .done  (mix_done),
    .home  (home)
  );

  lphm_store #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_store (
    .clk    (clk),
    .raddr  (issue_pos),
    .rd_key (rd_key),
    .rd_val (rd_val),
    .key_we (key_we),
    .val_we (val_we),
    .waddr  (waddr),
    .wr_key (wr_key),
    .wr_val (val_r)
  );

  // Classify the slot returned by the memory
  always_comb begin
    req_rsvd   = (req.key == lphm_pkg::KEY_EMPTY) || (req.key == lphm_pkg::KEY_TOMB);
    hit        = (rd_key == key_r);
    slot_empty = (rd_key == lphm_pkg::KEY_EMPTY);
    slot_free  = slot_empty || (rd_key == lphm_pkg::KEY_TOMB);
    free_any   = have_free || slot_free;
    free_sel   = have_free ? free_pos : chk_pos;
    probe_end  = (state == lphm_pkg::PROBE) && chk_vld &&
                 (hit || slot_empty || (nchk == LAST_IDX));
    ins_write  = probe_end && (func_r == lphm_pkg::FUNC_INSERT) && !hit && free_any;
    if (func_r == lphm_pkg::FUNC_INSERT) begin
      if (hit)           probe_status = lphm_pkg::STAT_DUP;
      else if (free_any) probe_status = lphm_pkg::STAT_OK;
      else               probe_status = lphm_pkg::STAT_FULL;
    end else begin
      probe_status = hit ? lphm_pkg::STAT_OK : lphm_pkg::STAT_NOT_FOUND;
    end
    probe_rv = ((func_r == lphm_pkg::FUNC_LOOKUP) && hit) ? rd_val : 64'h0;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lphm_pkg::CLEAR:  if (clr_idx == LAST_IDX) state_next = lphm_pkg::IDLE;
      lphm_pkg::IDLE: begin
        if (req_valid) state_next = req_rsvd ? lphm_pkg::FINISH : lphm_pkg::HASH;
      end
      lphm_pkg::HASH:   if (mix_done) state_next = lphm_pkg::PROBE;
      lphm_pkg::PROBE:  if (probe_end) state_next = lphm_pkg::FINISH;
      lphm_pkg::FINISH: if (!rsp_valid || rsp_ready) state_next = lphm_pkg::IDLE;
      default:          state_next = lphm_pkg::IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    req_ready = (state == lphm_pkg::IDLE);
    mix_start = (state == lphm_pkg::IDLE) && req_valid && !req_rsvd;
    rsp_load  = (state == lphm_pkg::FINISH) && (!rsp_valid || rsp_ready);
    if (state == lphm_pkg::CLEAR) begin
      key_we = 1'b1;
      val_we = 1'b0;
      waddr  = clr_idx;
      wr_key = lphm_pkg::KEY_EMPTY;
    end else begin
      key_we = ins_write;
      val_we = ins_write;
      waddr  = free_sel;
      wr_key = key_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lphm_pkg::CLEAR;
      clr_idx   <= '0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lphm_pkg::CLEAR) clr_idx <= clr_idx + ONE_IDX;
      if (state == lphm_pkg::PROBE) chk_vld <= 1'b1;
      else                          chk_vld <= 1'b0;
      if (rsp_load)       rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      func_r <= req.func;
      key_r  <= req.key;
      val_r  <= req.value;
    end
  end

  // Walk the probe path, one slot issued and one checked per cycle
  always_ff @(posedge clk) begin
    if (state == lphm_pkg::HASH) begin
      issue_pos <= home;
      nchk      <= '0;
      have_free <= 1'b0;
    end else if (state == lphm_pkg::PROBE) begin
      issue_pos <= (issue_pos == LAST_IDX) ? '0 : issue_pos + ONE_IDX;
      chk_pos   <= issue_pos;
      if (chk_vld) begin
        nchk      <= nchk + ONE_IDX;
        have_free <= free_any;
        free_pos  <= free_sel;
      end
    end
  end

  // Hold the outcome until the response register takes it
  always_ff @(posedge clk) begin
    if ((state == lphm_pkg::IDLE) && req_valid && req_rsvd) begin
      status_r <= lphm_pkg::STAT_RESERVED;
      rv_r     <= 64'h0;
    end else if (probe_end) begin
      status_r <= probe_status;
      rv_r     <= probe_rv;
    end
    if (rsp_load) begin
      rsp.status       <= status_r;
      rsp.result_value <= rv_r;
    end
  end

endmodule

// ----- hdl/lphm_mix.sv -----
// ----------------------------------------------------------------------------
// lphm_mix
// Home slot unit: 64-bit mix on one shared 32x32 multiplier, one 64-bit
// product at a time, then reduction modulo the table size four bits a cycle
// when the size is not a power of two.
// ----------------------------------------------------------------------------
module lphm_mix #(
  parameter  int unsigned TABLE_ENTRIES = 1024,
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      key,
  output logic             done,
  output logic [IDX_W-1:0] home
);

  localparam bit             POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [IDX_W:0] NT   = (IDX_W + 1)'(TABLE_ENTRIES);

  lphm_pkg::mix_state_t mst, mst_next;

  logic [1:0]       ph;
  logic [1:0]       mi;
  logic [63:0]      opnd;
  logic [63:0]      prod;
  logic [63:0]      acc;
  logic [63:0]      hsh;
  logic [IDX_W-1:0] rem;
  logic [3:0]       dcnt;

  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [31:0]      hi_sum;
  logic [63:0]      full;
  logic [63:0]      post;
  logic [IDX_W-1:0] rem_next;
  logic             mul_last;
  logic             mod_last;

  // Select partial product operands: lo*lo, lo*hi, hi*lo
  always_comb begin
    mul_a = (ph == 2'd2) ? opnd[63:32] : opnd[31:0];
    mul_b = (ph == 2'd1) ? lphm_pkg::MIX_MUL[63:32] : lphm_pkg::MIX_MUL[31:0];
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // Close the product and apply the step that follows it
  always_comb begin
    hi_sum = acc[63:32] + prod[31:0];
    full   = {hi_sum, acc[31:0]};
    case (mi)
      2'd1:    post = full ^ lphm_pkg::MIX_H0;
      default: post = full ^ (full >> lphm_pkg::MIX_SHIFT);
    endcase
  end

  // Reduce four hash bits per cycle modulo the table size
  always_comb begin
    logic [IDX_W-1:0] r;
    logic [IDX_W:0]   t;
    r = rem;
    for (int j = 0; j < 4; j++) begin
      t = {r, hsh[63-j]};
      if (t >= NT) t = t - NT;
      r = t[IDX_W-1:0];
    end
    rem_next = r;
  end

  // Next state
  always_comb begin
    mst_next = mst;
    case (mst)
      lphm_pkg::MIX_IDLE: if (start) mst_next = lphm_pkg::MIX_RUN;
      lphm_pkg::MIX_RUN: begin
        if (mul_last) mst_next = POW2 ? lphm_pkg::MIX_IDLE : lphm_pkg::MIX_MOD;
      end
      lphm_pkg::MIX_MOD: if (mod_last) mst_next = lphm_pkg::MIX_IDLE;
      default: mst_next = lphm_pkg::MIX_IDLE;
    endcase
  end

  // Step strobes
  always_comb begin
    mul_last = (mst == lphm_pkg::MIX_RUN) && (ph == 2'd3) && (mi == 2'd3);
    mod_last = (mst == lphm_pkg::MIX_MOD) && (dcnt == 4'hf);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mst  <= lphm_pkg::MIX_IDLE;
      done <= 1'b0;
    end else begin
      mst  <= mst_next;
      done <= (mul_last && POW2) || mod_last;
    end
  end

  // Multiply sequence
  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= key;
      ph   <= 2'd0;
      mi   <= 2'd0;
    end else if (mst == lphm_pkg::MIX_RUN) begin
      prod <= mul_p;
      ph   <= ph + 2'd1;
      case (ph)
        2'd1: acc <= prod;
        2'd2: acc[63:32] <= hi_sum;
        2'd3: begin
          opnd <= post;
          mi   <= mi + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Reduction and home slot
  always_ff @(posedge clk) begin
    if (mul_last) begin
      hsh  <= post;
      rem  <= '0;
      dcnt <= 4'h0;
    end else if (mst == lphm_pkg::MIX_MOD) begin
      hsh  <= {hsh[59:0], 4'h0};
      rem  <= rem_next;
      dcnt <= dcnt + 4'h1;
    end
    if (mul_last && POW2) begin
      home <= post[IDX_W-1:0];
    end else if (mod_last) begin
      home <= rem_next;
    end
  end

endmodule

// ----- hdl/lphm_store.sv -----
// ----------------------------------------------------------------------------
// lphm_store
// Key and value memories: one write port each, one shared read address,
// read data registered.
// ----------------------------------------------------------------------------
module lphm_store #(
  parameter  int unsigned TABLE_ENTRIES = 1024,
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] raddr,
  output logic [63:0]      rd_key,
  output logic [63:0]      rd_val,
  input  logic             key_we,
  input  logic             val_we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [63:0]      wr_key,
  input  logic [63:0]      wr_val
);

  logic [63:0] key_mem [TABLE_ENTRIES];
  logic [63:0] val_mem [TABLE_ENTRIES];

  // Key memory
  always_ff @(posedge clk) begin
    if (key_we) key_mem[waddr] <= wr_key;
    rd_key <= key_mem[raddr];
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (val_we) val_mem[waddr] <= wr_val;
    rd_val <= val_mem[raddr];
  end

endmodule

// ----- hdl/lphm_checker.sv -----
// ----------------------------------------------------------------------------
// lphm_checker
// Port level checks for the linear probing hash map, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_macros.svh"

module lphm_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input lphm_pkg::out_t rsp
);

  // Hold a stalled response beat
  `LPHM_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)), "stalled response changed")

  // Report a value only on a successful lookup status
  `LPHM_ASSERT(a_rv_zero, clk, rst, (rsp_valid && (rsp.status != lphm_pkg::STAT_OK)) |-> (rsp.result_value == 64'h0), "nonzero value with failing status")

  // Take one request at a time
  `LPHM_ASSERT(a_one_item, clk, rst, (req_valid && req_ready) |=> !req_ready, "request taken while one is in flight")

  // Keep requests out right after reset, when the clearing sweep starts
  `LPHM_ASSERT_ALWAYS(a_clear_block, clk, rst |=> !req_ready, "request taken right after reset")

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (.*);

// ----- dv/linear_probe_hash_map_test.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_map_test
// Self-checking bench for the linear probing hash map.
// ----------------------------------------------------------------------------
// A shadow copy of the key and value memories predicts the response beats.
// A short table of directed requests covers the reserved keys, duplicates,
// extreme keys and values and lookups on an empty table. Random traffic then
// fills the table to the last slot, so that full-table inserts and long
// lookups are also covered. Both sides idle in random bursts. At two points
// the response side holds off for a long stretch. At another the request
// side waits until every response has come back.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_test;

  localparam int unsigned SLOTS        = 1024;
  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned CALM_START   = 1750;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam longint unsigned TIMEOUT_CYCLES = 10_000_000;
  localparam int unsigned NUM_ROWS     = 23;

  // One directed request, with its response typed in where it is obvious
  typedef struct packed {
    lphm_pkg::in_t  beat;
    logic           typed;
    lphm_pkg::out_t rsp;
  } dir_row_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  lphm_pkg::in_t  req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  lphm_pkg::out_t rsp;

  // Shadow of the block's memories
  logic [63:0] shadow_keys [SLOTS];
  logic [63:0] shadow_vals [SLOTS];
  int unsigned shadow_fill;
  logic [63:0] known_keys [$];

  lphm_pkg::out_t pending_rsp [$];
  dir_row_t       dir_rows [NUM_ROWS];
  int unsigned    mismatch_count = 0;
  int unsigned    beats_sent     = 0;
  int unsigned    status_seen [8];
  logic           calm     = 1'b0;
  logic           hold_rsp = 1'b0;

  linear_probe_hash_map #(
    .TABLE_ENTRIES(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Murmur-style 64-bit mix of a key
  function automatic logic [63:0] key_mix(input logic [63:0] k);
    logic [63:0] h;
    logic [63:0] m;
    h = lphm_pkg::MIX_SEED ^ (lphm_pkg::MIX_MUL * 64'd8);
    m = k * lphm_pkg::MIX_MUL;
    m = m ^ (m >> lphm_pkg::MIX_SHIFT);
    m = m * lphm_pkg::MIX_MUL;
    h = h ^ m;
    h = h * lphm_pkg::MIX_MUL;
    h = h ^ (h >> lphm_pkg::MIX_SHIFT);
    h = h * lphm_pkg::MIX_MUL;
    h = h ^ (h >> lphm_pkg::MIX_SHIFT);
    return h;
  endfunction

  // Apply one request to the shadow memories and return its response
  function automatic lphm_pkg::out_t map_access(input lphm_pkg::in_t beat);
    lphm_pkg::out_t r;
    logic [63:0]    home;
    int unsigned    slot;
    int unsigned    walked;
    int unsigned    free_slot;
    logic           have_free;
    logic           done;
    logic [63:0]    cur;
    r.status       = lphm_pkg::STAT_NOT_FOUND;
    r.result_value = '0;
    have_free      = 1'b0;
    free_slot      = 0;
    done           = 1'b0;
    walked         = 0;
    home           = key_mix(beat.key) % 64'(SLOTS);
    slot           = int'(home);
    if (beat.key == lphm_pkg::KEY_EMPTY || beat.key == lphm_pkg::KEY_TOMB) begin
      r.status = lphm_pkg::STAT_RESERVED;
    end else if (beat.func == lphm_pkg::FUNC_LOOKUP) begin
      // walk until a match or an empty slot; skip tombstones
      while (!done && walked < SLOTS) begin
        cur = shadow_keys[slot];
        if (cur == beat.key) begin
          r.status       = lphm_pkg::STAT_OK;
          r.result_value = shadow_vals[slot];
          done           = 1'b1;
        end else if (cur == lphm_pkg::KEY_EMPTY) begin
          done = 1'b1;
        end else begin
          slot = (slot + 1 >= SLOTS) ? 0 : slot + 1;
          walked++;
        end
      end
    end else begin
      // walk for a duplicate, remember the first free slot passed
      while (!done && walked < SLOTS) begin
        cur = shadow_keys[slot];
        if (cur == beat.key) begin
          r.status = lphm_pkg::STAT_DUP;
          done     = 1'b1;
        end else begin
          if ((cur == lphm_pkg::KEY_EMPTY || cur == lphm_pkg::KEY_TOMB) && !have_free) begin
            have_free = 1'b1;
            free_slot = slot;
          end
          if (cur == lphm_pkg::KEY_EMPTY) begin
            done = 1'b1;
          end else begin
            slot = (slot + 1 >= SLOTS) ? 0 : slot + 1;
            walked++;
          end
        end
      end
      if (r.status != lphm_pkg::STAT_DUP) begin
        if (have_free) begin
          shadow_keys[free_slot] = beat.key;
          shadow_vals[free_slot] = beat.value;
          shadow_fill++;
          known_keys = {known_keys, beat.key};
          r.status = lphm_pkg::STAT_OK;
        end else begin
          r.status = lphm_pkg::STAT_FULL;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] any_known_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  function automatic dir_row_t row(input logic f, input logic [63:0] k, input logic [63:0] v,
                                   input logic typed, input logic [2:0] st,
                                   input logic [63:0] rv);
    dir_row_t d;
    d.beat.func         = f;
    d.beat.key          = k;
    d.beat.value        = v;
    d.typed             = typed;
    d.rsp.status        = st;
    d.rsp.result_value  = rv;
    return d;
  endfunction

  // Offer one request beat, idling first at random; predict on acceptance
  task automatic offer_request(input lphm_pkg::in_t beat, input logic typed,
                               input lphm_pkg::out_t typed_rsp);
    lphm_pkg::out_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req       = beat;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    predicted = map_access(beat);
    pending_rsp = {pending_rsp, typed ? typed_rsp : predicted};
    beats_sent++;
    status_seen[predicted.status]++;
    @(negedge clk);
  endtask

  // Pace the response side: random stalls, two long hold-offs, none at the end
  initial begin : rsp_pacer
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (calm) begin
        rsp_ready = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        rsp_ready = 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        rsp_ready = 1'b1;
      end
    end
  end

  // Compare each response beat with the oldest expectation
  always @(posedge clk) begin : rsp_check
    lphm_pkg::out_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, got status %0d value %h",
                 $time, rsp.status, rsp.result_value);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.result_value !== want.result_value) begin
          $display("%0t: result_value mismatch, expected %h, got %h",
                   $time, want.result_value, rsp.result_value);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    lphm_pkg::in_t beat;
    int unsigned   pick;
    int unsigned   idx;
    for (idx = 0; idx < SLOTS; idx++) begin
      shadow_keys[idx] = lphm_pkg::KEY_EMPTY;
      shadow_vals[idx] = '0;
    end
    shadow_fill = 0;
    for (idx = 0; idx < 8; idx++) status_seen[idx] = 0;

    // reserved keys, empty table, extremes, duplicates
    dir_rows[0]  = row(lphm_pkg::FUNC_LOOKUP, 64'd0, 64'd0, 1'b1,
                       lphm_pkg::STAT_NOT_FOUND, 64'd0);
    dir_rows[1]  = row(lphm_pkg::FUNC_LOOKUP, lphm_pkg::KEY_EMPTY, '1, 1'b1,
                       lphm_pkg::STAT_RESERVED, 64'd0);
    dir_rows[2]  = row(lphm_pkg::FUNC_INSERT, lphm_pkg::KEY_EMPTY, 64'd7, 1'b1,
                       lphm_pkg::STAT_RESERVED, 64'd0);
    dir_rows[3]  = row(lphm_pkg::FUNC_LOOKUP, lphm_pkg::KEY_TOMB, 64'd0, 1'b1,
                       lphm_pkg::STAT_RESERVED, 64'd0);
    dir_rows[4]  = row(lphm_pkg::FUNC_INSERT, lphm_pkg::KEY_TOMB, '1, 1'b1,
                       lphm_pkg::STAT_RESERVED, 64'd0);
    dir_rows[5]  = row(lphm_pkg::FUNC_INSERT, 64'd0, '1, 1'b1, lphm_pkg::STAT_OK, 64'd0);
    dir_rows[6]  = row(lphm_pkg::FUNC_LOOKUP, 64'd0, 64'h1234, 1'b1, lphm_pkg::STAT_OK, '1);
    dir_rows[7]  = row(lphm_pkg::FUNC_INSERT, 64'd0, 64'd5, 1'b1, lphm_pkg::STAT_DUP, 64'd0);
    dir_rows[8]  = row(lphm_pkg::FUNC_INSERT, 64'hffff_ffff_ffff_fffd, 64'd0, 1'b1,
                       lphm_pkg::STAT_OK, 64'd0);
    dir_rows[9]  = row(lphm_pkg::FUNC_LOOKUP, 64'hffff_ffff_ffff_fffd, '1, 1'b1,
                       lphm_pkg::STAT_OK, 64'd0);
    dir_rows[10] = row(lphm_pkg::FUNC_INSERT, 64'h8000_0000_0000_0000,
                       64'h8000_0000_0000_0001, 1'b1, lphm_pkg::STAT_OK, 64'd0);
    dir_rows[11] = row(lphm_pkg::FUNC_LOOKUP, 64'h8000_0000_0000_0000, 64'd0,
                       1'b1, lphm_pkg::STAT_OK, 64'h8000_0000_0000_0001);
    dir_rows[12] = row(lphm_pkg::FUNC_LOOKUP, 64'd1, 64'd0, 1'b1,
                       lphm_pkg::STAT_NOT_FOUND, 64'd0);
    dir_rows[13] = row(lphm_pkg::FUNC_INSERT, 64'd1, 64'h5555_5555_5555_5555, 1'b1,
                       lphm_pkg::STAT_OK, 64'd0);
    dir_rows[14] = row(lphm_pkg::FUNC_INSERT, 64'haaaa_aaaa_aaaa_aaaa,
                       64'haaaa_aaaa_aaaa_aaaa, 1'b1, lphm_pkg::STAT_OK, 64'd0);
    dir_rows[15] = row(lphm_pkg::FUNC_LOOKUP, 64'd1, 64'd0, 1'b1,
                       lphm_pkg::STAT_OK, 64'h5555_5555_5555_5555);
    dir_rows[16] = row(lphm_pkg::FUNC_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 64'd0,
                       1'b1, lphm_pkg::STAT_OK, 64'haaaa_aaaa_aaaa_aaaa);
    dir_rows[17] = row(lphm_pkg::FUNC_INSERT, 64'h7fff_ffff_ffff_ffff, '1, 1'b1,
                       lphm_pkg::STAT_OK, 64'd0);
    dir_rows[18] = row(lphm_pkg::FUNC_LOOKUP, 64'h7fff_ffff_ffff_ffff, 64'd0, 1'b1,
                       lphm_pkg::STAT_OK, '1);
    dir_rows[19] = row(lphm_pkg::FUNC_INSERT, 64'hffff_ffff_ffff_fffd, '1, 1'b1,
                       lphm_pkg::STAT_DUP, 64'd0);
    dir_rows[20] = row(lphm_pkg::FUNC_LOOKUP, 64'hffff_ffff_ffff_fffc, 64'd0,
                       1'b1, lphm_pkg::STAT_NOT_FOUND, 64'd0);
    dir_rows[21] = row(lphm_pkg::FUNC_INSERT, 64'h0123_4567_89ab_cdef,
                       64'hfedc_ba98_7654_3210, 1'b0, lphm_pkg::STAT_OK, 64'd0);
    dir_rows[22] = row(lphm_pkg::FUNC_LOOKUP, 64'h0123_4567_89ab_cdef, 64'd0, 1'b0,
                       lphm_pkg::STAT_OK, 64'd0);

    // hold reset, then release at a falling edge
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed rows
    for (idx = 0; idx < NUM_ROWS; idx++) begin
      offer_request(dir_rows[idx].beat, dir_rows[idx].typed, dir_rows[idx].rsp);
    end

    // random traffic, mostly fresh inserts so the table fills up
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx == CALM_START) calm = 1'b1;
      if (idx == 400 || idx == 1300) hold_rsp = 1'b1;
      if (idx == 900) begin
        // drain everything before going on
        req_valid = 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (shadow_fill >= SLOTS && pick >= 3 && pick < 60) pick = 60 + pick % 30;
      beat.func  = lphm_pkg::FUNC_INSERT;
      beat.key   = rand64();
      beat.value = rand64();
      if (pick >= 60 && pick < 70) begin
        beat.key = any_known_key();
      end else if (pick >= 70 && pick < 90) begin
        beat.func = lphm_pkg::FUNC_LOOKUP;
        beat.key  = any_known_key();
      end else if (pick >= 90 && pick < 96) begin
        beat.func = lphm_pkg::FUNC_LOOKUP;
      end else if (pick >= 96 && pick < 98) begin
        beat.func = $urandom_range(0, 1) ? lphm_pkg::FUNC_INSERT : lphm_pkg::FUNC_LOOKUP;
        beat.key  = $urandom_range(0, 1) ? lphm_pkg::KEY_EMPTY : lphm_pkg::KEY_TOMB;
      end else if (pick >= 98) begin
        beat.func = $urandom_range(0, 1) ? lphm_pkg::FUNC_INSERT : lphm_pkg::FUNC_LOOKUP;
        beat.key  = {48'hffff_ffff_ffff, 16'($urandom)};
      end
      offer_request(beat, 1'b0, '0);
    end

    // top off the table, then work on it while full
    while (shadow_fill < SLOTS) begin
      beat.func  = lphm_pkg::FUNC_INSERT;
      beat.key   = rand64();
      beat.value = rand64();
      offer_request(beat, 1'b0, '0);
    end
    for (idx = 0; idx < 16; idx++) begin
      beat.value = rand64();
      case (idx % 4)
        0: begin
          beat.func = lphm_pkg::FUNC_INSERT;
          beat.key  = rand64();
        end
        1: begin
          beat.func = lphm_pkg::FUNC_LOOKUP;
          beat.key  = rand64();
        end
        2: begin
          beat.func = lphm_pkg::FUNC_LOOKUP;
          beat.key  = any_known_key();
        end
        default: begin
          beat.func = lphm_pkg::FUNC_INSERT;
          beat.key  = any_known_key();
        end
      endcase
      offer_request(beat, 1'b0, '0);
    end

    // drain and let the block settle
    req_valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d requests; table filled to %0d of %0d slots.",
             beats_sent, shadow_fill, SLOTS);
    $display("Responses: ok %0d, not found %0d, full %0d, duplicate %0d, reserved %0d.",
             status_seen[lphm_pkg::STAT_OK], status_seen[lphm_pkg::STAT_NOT_FOUND],
             status_seen[lphm_pkg::STAT_FULL], status_seen[lphm_pkg::STAT_DUP],
             status_seen[lphm_pkg::STAT_RESERVED]);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
